// ===== src/pts_pkg.sv =====
// Shared types and constants of the perceptron training step unit.
package pts_pkg;

    // Fixed field widths
    localparam int FEAT_BITS  = 16;
    localparam int CNT_BITS   = 16;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_LSB = 2;
    localparam logic [CFG_ADDR_W-1:CFG_IDX_LSB] REG_STOP_RUN = 1'b0;
    localparam logic [CNT_BITS-1:0] STOP_RUN_RESET = 16'd1280;

    // One beat on the input channel
    typedef struct packed {
        logic signed [FEAT_BITS-1:0] feature;
        logic                        label;
        logic                        last_element;
        logic                        start_trial;
    } t_in_item;

    // One beat on the result channel
    typedef struct packed {
        logic                mistake;
        logic [CNT_BITS-1:0] update_count;
        logic [CNT_BITS-1:0] correct_run;
        logic                converged;
    } t_out_item;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_DECIDE,
        S_WRD,
        S_WWR,
        S_DONE
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic mul;
        logic acc;
        logic decide;
        logic walk_rd;
        logic walk_wr;
        logic out_load;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic last;
        logic mistake;
        logic walk_more;
        logic out_free;
    } t_sts;

endpackage

// ===== src/pts_cfg.sv =====
// APB-style configuration register block holding stop_run.
module pts_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pts_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [pts_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [pts_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                pready,
    output logic [pts_pkg::CNT_BITS-1:0]        o_stop_run
);

    logic [pts_pkg::CNT_BITS-1:0] r_stop_run;
    logic                         hit_stop_run;

    assign hit_stop_run =
        (paddr[pts_pkg::CFG_ADDR_W-1:pts_pkg::CFG_IDX_LSB] == pts_pkg::REG_STOP_RUN);

    // Write on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_run <= pts_pkg::STOP_RUN_RESET;
        end else if (psel && penable && pwrite && pready && hit_stop_run) begin
            r_stop_run <= pwdata[pts_pkg::CNT_BITS-1:0];
        end
    end

    // Read back
    assign prdata = hit_stop_run ? pts_pkg::CFG_DATA_W'(r_stop_run) : '0;
    assign pready = 1'b1;
    assign o_stop_run = r_stop_run;

endmodule

// ===== src/pts_ctrl.sv =====
// Controller state machine sequencing accumulate, decide and weight update.
module pts_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  pts_pkg::t_sts i_sts,
    output pts_pkg::t_cmd o_cmd
);

    pts_pkg::t_state r_state;
    pts_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pts_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pts_pkg::S_IDLE: begin
                if (i_in_valid) n_state = pts_pkg::S_MUL;
            end
            pts_pkg::S_MUL: begin
                n_state = pts_pkg::S_ACC;
            end
            pts_pkg::S_ACC: begin
                n_state = i_sts.last ? pts_pkg::S_DECIDE : pts_pkg::S_IDLE;
            end
            pts_pkg::S_DECIDE: begin
                n_state = i_sts.mistake ? pts_pkg::S_WRD : pts_pkg::S_DONE;
            end
            pts_pkg::S_WRD: begin
                n_state = i_sts.walk_more ? pts_pkg::S_WWR : pts_pkg::S_DONE;
            end
            pts_pkg::S_WWR: begin
                n_state = pts_pkg::S_WRD;
            end
            pts_pkg::S_DONE: begin
                if (i_sts.out_free) n_state = pts_pkg::S_IDLE;
            end
            default: begin
                n_state = pts_pkg::S_IDLE;
            end
        endcase
    end

    // Commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            pts_pkg::S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            pts_pkg::S_MUL:    o_cmd.mul     = 1'b1;
            pts_pkg::S_ACC:    o_cmd.acc     = 1'b1;
            pts_pkg::S_DECIDE: o_cmd.decide  = 1'b1;
            pts_pkg::S_WRD:    o_cmd.walk_rd = i_sts.walk_more;
            pts_pkg::S_WWR:    o_cmd.walk_wr = 1'b1;
            pts_pkg::S_DONE:   o_cmd.out_load = i_sts.out_free;
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== src/pts_dp.sv =====
// Datapath: weight and sample memories, multiply-accumulate, counters, result register.
module pts_dp #(
    parameter int DIM         = 13,
    parameter int WEIGHT_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pts_pkg::t_in_item            i_in_data,
    input  pts_pkg::t_cmd                i_cmd,
    output pts_pkg::t_sts                o_sts,
    input  logic [pts_pkg::CNT_BITS-1:0] i_stop_run,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output pts_pkg::t_out_item           o_out_data
);

    localparam int FB     = pts_pkg::FEAT_BITS;
    localparam int CB     = pts_pkg::CNT_BITS;
    localparam int CNT_W  = $clog2(DIM + 1);
    localparam int IDX_W  = $clog2(DIM);
    localparam int PROD_W = WEIGHT_BITS + FB;
    localparam int ACC_W  = PROD_W + $clog2(DIM);
    localparam int SUM_W  = WEIGHT_BITS + 1;
    localparam logic signed [WEIGHT_BITS-1:0] W_MAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
    localparam logic signed [WEIGHT_BITS-1:0] W_MIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};

    // Memories
    logic signed [WEIGHT_BITS-1:0] r_wmem [DIM];
    logic signed [FB-1:0]          r_smem [DIM];
    logic [DIM-1:0]                r_wvld;
    logic signed [WEIGHT_BITS-1:0] r_w_rd;
    logic signed [FB-1:0]          r_s_rd;
    logic                          r_w_ok;

    // Sample state
    logic [CNT_W-1:0]       r_idx;
    logic [CNT_W-1:0]       r_walk;
    logic signed [FB-1:0]   r_feat;
    logic                   r_last;
    logic                   r_label;
    logic                   r_inrange;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic                   r_mistake;
    logic [CB-1:0]          r_run;
    logic [CB-1:0]          r_upd;
    logic                   r_out_valid;
    pts_pkg::t_out_item     r_out_data;

    logic                   acc_in_range;
    logic [IDX_W-1:0]       acc_addr;
    logic [IDX_W-1:0]       rd_addr;
    logic                   rd_en;
    logic                   start_now;
    logic signed [PROD_W-1:0] prod_c;
    logic                   positive;
    logic                   mistake_c;
    logic signed [SUM_W-1:0] w_ext;
    logic signed [SUM_W-1:0] s_ext;
    logic signed [SUM_W-1:0] sum_c;
    logic signed [WEIGHT_BITS-1:0] n_weight;

    // Address selection
    assign start_now    = i_cmd.accept && i_in_data.start_trial;
    assign acc_in_range = i_in_data.start_trial || (r_idx < CNT_W'(DIM));
    assign acc_addr     = i_in_data.start_trial ? '0 : r_idx[IDX_W-1:0];
    assign rd_addr      = i_cmd.walk_rd ? r_walk[IDX_W-1:0] : acc_addr;
    assign rd_en        = (i_cmd.accept && acc_in_range) || i_cmd.walk_rd;

    // Memory ports
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_w_rd <= r_wmem[rd_addr];
            r_s_rd <= r_smem[rd_addr];
            r_w_ok <= r_wvld[rd_addr] && !start_now;
        end
        if (i_cmd.accept && acc_in_range) begin
            r_smem[acc_addr] <= i_in_data.feature;
        end
        if (i_cmd.walk_wr) begin
            r_wmem[r_walk[IDX_W-1:0]] <= n_weight;
        end
    end

    // Weight valid bits: an entry not yet written reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || start_now) begin
            r_wvld <= '0;
        end else if (i_cmd.walk_wr) begin
            r_wvld[r_walk[IDX_W-1:0]] <= 1'b1;
        end
    end

    // Latch the accepted beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_feat    <= i_in_data.feature;
            r_last    <= i_in_data.last_element;
            r_label   <= i_in_data.label;
            r_inrange <= acc_in_range;
        end
    end

    // Multiply stage
    assign prod_c = r_w_rd * r_feat;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= (r_w_ok && r_inrange) ? prod_c : '0;
        end
    end

    // Decision on the full sum; zero predicts -1
    assign positive  = !r_acc[ACC_W-1] && (r_acc != '0);
    assign mistake_c = positive != r_label;

    // Weight update: add or subtract the buffered feature, saturating
    assign w_ext = r_w_ok ? SUM_W'(r_w_rd) : '0;
    assign s_ext = SUM_W'(r_s_rd);
    assign sum_c = r_label ? (w_ext + s_ext) : (w_ext - s_ext);

    always_comb begin
        if (sum_c[SUM_W-1] != sum_c[SUM_W-2]) begin
            n_weight = sum_c[SUM_W-1] ? W_MIN : W_MAX;
        end else begin
            n_weight = sum_c[WEIGHT_BITS-1:0];
        end
    end

    // Accumulator, element index and walk index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_idx  <= '0;
            r_walk <= '0;
        end else begin
            if (i_cmd.accept) begin
                if (start_now) r_acc <= '0;
                if (acc_in_range) r_idx <= CNT_W'(acc_addr) + CNT_W'(1);
            end
            if (i_cmd.acc) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
            if (i_cmd.decide) begin
                r_walk <= '0;
            end
            if (i_cmd.walk_wr) begin
                r_walk <= r_walk + CNT_W'(1);
            end
            if (i_cmd.out_load) begin
                r_acc <= '0;
                r_idx <= '0;
            end
        end
    end

    // Run and update counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || start_now) begin
            r_run     <= '0;
            r_upd     <= '0;
            r_mistake <= 1'b0;
        end else if (i_cmd.decide) begin
            r_mistake <= mistake_c;
            if (mistake_c) begin
                r_run <= '0;
                if (r_upd != '1) r_upd <= r_upd + CB'(1);
            end else if (r_run != '1) begin
                r_run <= r_run + CB'(1);
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data.mistake      <= r_mistake;
            r_out_data.update_count <= r_upd;
            r_out_data.correct_run  <= r_run;
            r_out_data.converged    <= (r_run >= i_stop_run);
        end
    end

    // Status
    assign o_sts.last      = r_last;
    assign o_sts.mistake   = mistake_c;
    assign o_sts.walk_more = r_walk < r_idx;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== src/perceptron_training_step_unit.sv =====
// An element passes through accept, multiply and accumulate before the next is taken.
// The last element then goes to decide and to done, which loads the result once the result
// register is free; a mistake first walks the weights of each stored element (at most DIM).
// Rate is set by the shared 32x16 multiplier and the single-port weight memory.
// Reset (i_rst_n, synchronous, active low) clears counters, control and weight valid bits
// at once, so weights read as zero; stop_run returns to 1280. No clearing pass is needed.
module perceptron_training_step_unit #(
    parameter int DIM         = 13,
    parameter int WEIGHT_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  pts_pkg::t_in_item                  i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output pts_pkg::t_out_item                 o_out_data,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pts_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [pts_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [pts_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                               pready
);

    pts_pkg::t_cmd                cmd;
    pts_pkg::t_sts                sts;
    logic [pts_pkg::CNT_BITS-1:0] stop_run;

    // Configuration registers
    pts_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_stop_run (stop_run)
    );

    // Sequencer
    pts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Arithmetic and storage
    pts_dp #(
        .DIM         (DIM),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_stop_run  (stop_run),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== src/pts_checker.sv =====
// Port-level checks for the perceptron training step unit, with its bind.
module pts_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input pts_pkg::t_out_item o_out_data
);

    // Hold a result beat until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat dropped or changed while stalled");

    // Drop ready after each accepted beat while it is worked on
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken again before the element was processed");

    // A mistake restarts the run of correct samples
    a_mistake_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.mistake |-> o_out_data.correct_run == '0)
        else $error("run not cleared on a mistake");

    // A correct sample leaves a non-zero run
    a_correct_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.mistake |-> o_out_data.correct_run != '0)
        else $error("run not advanced on a correct sample");

endmodule

bind perceptron_training_step_unit pts_checker u_pts_checker (.*);
